// File: rtl/assert_macros.svh
// Assertion macros shared by the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define DULAW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define DULAW_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`else

`define DULAW_ASSERT(lbl, clk, rst_n, prop, msg)
`define DULAW_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: rtl/dulaw_pkg.sv
// Package: constants and the u-law encode function for the decimating encoder.
package dulaw_pkg;

    // Default sample width (Q1.23).
    localparam int INPUT_BITS_DEF = 24;

    // Decimation register and phase counter widths.
    localparam int FACTOR_W = 7;
    localparam int PHASE_W  = 6;
    localparam logic [FACTOR_W-1:0] MAX_PERIOD    = 7'd64;
    localparam logic [FACTOR_W-1:0] FACTOR_RESET  = 7'd1;

    // Linear PCM magnitude width and u-law constants.
    localparam int PCM_W = 15;
    localparam logic [PCM_W-1:0] PCM_SCALE = 15'd32767;
    localparam logic [PCM_W-1:0] ULAW_CLIP = 15'd32635;
    localparam logic [15:0]      ULAW_BIAS = 16'h0084;

    // G.711 u-law encode of a sign and a 15-bit magnitude.
    function automatic logic [7:0] ulaw_encode(input logic neg, input logic [PCM_W-1:0] mag);
        logic [PCM_W-1:0] clip;
        logic [15:0]      v;
        logic [7:0]       top;
        logic [2:0]       expo;
        logic [3:0]       mant;
        clip = (mag > ULAW_CLIP) ? ULAW_CLIP : mag;
        v    = {1'b0, clip} + ULAW_BIAS;
        top  = v[14:7];
        // exponent is the index of the leading one in the top byte
        expo = '0;
        for (int i = 1; i < 8; i++) begin
            if (top[i]) expo = 3'(i);
        end
        mant = 4'(v >> (5'(expo) + 5'd3));
        return ~{neg, expo, mant};
    endfunction

endpackage

// File: rtl/dulaw_decim.sv
// Decimation control: factor register and phase counter, keep decision per item.
`include "assert_macros.svh"

module dulaw_decim (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dulaw_pkg::FACTOR_W-1:0] i_cfg_data,
    input  logic                          i_accept,
    output logic                          o_keep
);

    logic [dulaw_pkg::FACTOR_W-1:0] r_factor;
    logic [dulaw_pkg::PHASE_W-1:0]  r_phase;
    logic [dulaw_pkg::PHASE_W-1:0]  n_phase;
    logic [dulaw_pkg::FACTOR_W-1:0] eff_factor;
    logic [dulaw_pkg::FACTOR_W-1:0] phase_inc;

    // Factor register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= dulaw_pkg::FACTOR_RESET;
        end else if (i_cfg_we) begin
            r_factor <= i_cfg_data;
        end
    end

    // Zero acts as one, anything past the counter period saturates
    always_comb begin
        if (r_factor == '0) begin
            eff_factor = dulaw_pkg::FACTOR_RESET;
        end else if (r_factor > dulaw_pkg::MAX_PERIOD) begin
            eff_factor = dulaw_pkg::MAX_PERIOD;
        end else begin
            eff_factor = r_factor;
        end
    end

    // Phase advance with wrap; a phase at or past the factor also wraps
    assign phase_inc = {1'b0, r_phase} + 1'b1;
    assign n_phase   = (phase_inc >= eff_factor) ? '0 : r_phase + 1'b1;
    assign o_keep    = (r_phase == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
        end
    end

    `DULAW_ASSERT(a_phase_idle, i_clk, i_rst_n, !i_accept |=> $stable(r_phase), "phase moved without an item")
    `DULAW_ASSERT(a_factor_one, i_clk, i_rst_n, i_accept && eff_factor == dulaw_pkg::FACTOR_RESET |=> r_phase == '0, "factor one must keep every item")

endmodule

// File: rtl/dulaw_core.sv
// Encode pipeline: input register, scale and u-law encode, output register.
`include "assert_macros.svh"

module dulaw_core #(
    parameter int INPUT_BITS = dulaw_pkg::INPUT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic [INPUT_BITS-1:0] i_sample_in,
    input  logic                  i_stall,
    output logic                  o_full,
    output logic                  o_valid,
    output logic [7:0]            o_ulaw_code
);

    localparam int PROD_W = INPUT_BITS + dulaw_pkg::PCM_W;

    logic                           r_s1_valid;
    logic                           r_s1_neg;
    logic [INPUT_BITS-1:0]          r_s1_mag;
    logic                           r_out_valid;
    logic [7:0]                     r_code;
    logic                           s1_adv;
    logic                           in_neg;
    logic [INPUT_BITS-1:0]          in_mag;
    logic [PROD_W-1:0]              prod;
    logic [dulaw_pkg::PCM_W-1:0]    pcm_mag;
    logic [7:0]                     n_code;

    // Sign and magnitude at the input; most negative wraps to full scale
    assign in_neg = i_sample_in[INPUT_BITS-1];
    assign in_mag = in_neg ? (~i_sample_in + 1'b1) : i_sample_in;

    // Stage 1 moves on when the output register is empty or being taken
    assign s1_adv = !r_out_valid || !i_stall;
    assign o_full = r_s1_valid && !s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_load) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1_neg <= in_neg;
            r_s1_mag <= in_mag;
        end
    end

    // Scale to 16-bit PCM: (mag * 32767) >> (INPUT_BITS-1), then encode
    assign prod    = PROD_W'(r_s1_mag) * PROD_W'(dulaw_pkg::PCM_SCALE);
    assign pcm_mag = prod[INPUT_BITS-1 +: dulaw_pkg::PCM_W];
    assign n_code  = dulaw_pkg::ulaw_encode(r_s1_neg && (pcm_mag != '0), pcm_mag);

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_code <= n_code;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_ulaw_code = r_code;

    `DULAW_ASSERT(a_s1_to_out, i_clk, i_rst_n, r_s1_valid && s1_adv |=> r_out_valid, "stage 1 item lost")
    `DULAW_ASSERT(a_no_repeat, i_clk, i_rst_n, r_out_valid && !i_stall && !r_s1_valid |=> !r_out_valid, "item delivered twice")
    `DULAW_NEVER(a_load_full, i_clk, i_rst_n, i_load && o_full, "load into a blocked stage")

endmodule

// File: rtl/decimating_ulaw_encoder_unit.sv
// Top level of the decimating G.711 u-law encoder.
//
// Input channel: i_valid / o_stall with i_sample_in, a signed Q1.(INPUT_BITS-1)
// sample. An item is taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_ulaw_code, one G.711 u-law byte.
// Configuration: i_cfg_we writes i_cfg_data into the decimation factor;
// one item in every factor is encoded, the rest are dropped (zero is one,
// above 64 counts as 64).
// Path: a kept item is taken into the input register and passes into the output
// register before it shows on o_valid; i_stall can hold it in the input register.
// Throughput: one item per cycle while o_stall is low; the input register feeds
// scale and encode logic into the output register, so the result register holds
// a waiting code while the next item is taken into the input register.
// Stall: when i_stall holds a valid result and the input register is full,
// o_stall rises in the same cycle; no item is lost or repeated.
// Reset (i_rst_n low, synchronous): both pipeline stages empty, phase zero,
// factor one.
module decimating_ulaw_encoder_unit #(
    parameter int INPUT_BITS = dulaw_pkg::INPUT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dulaw_pkg::FACTOR_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [INPUT_BITS-1:0]          i_sample_in,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [7:0]                     o_ulaw_code
);

    logic accept;
    logic keep;
    logic full;

    // Input handshake
    assign o_stall = full;
    assign accept  = i_valid && !full;

    dulaw_decim u_decim (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .o_keep     (keep)
    );

    dulaw_core #(
        .INPUT_BITS (INPUT_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept && keep),
        .i_sample_in (i_sample_in),
        .i_stall     (i_stall),
        .o_full      (full),
        .o_valid     (o_valid),
        .o_ulaw_code (o_ulaw_code)
    );

endmodule
